// ===== hw/rtl/cmm_pkg.sv =====
`timescale 1ns / 1ps

package cmm_pkg;

	localparam int DIM = 3;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 3;
	localparam int COMP_W = 16;
	localparam int ELEM_W = 2 * COMP_W;
	localparam int PROD_W = 2 * COMP_W;
	localparam int CPX_W  = PROD_W + 1;
	localparam int ACC_W  = 36;

	localparam int DEPTH  = DIM * DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = (DIM > 1) ? $clog2(DIM) : 1;

	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_k;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} ctl_t;

endpackage

// ===== hw/rtl/cmm_ram.sv =====
`timescale 1ns / 1ps

module cmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/cmm_cmac.sv =====
`timescale 1ns / 1ps

module cmm_cmac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cmm_pkg::ctl_t                           ctl_s1,
	input  logic [cmm_pkg::ELEM_W-1:0]              a_s1,
	input  logic [cmm_pkg::ELEM_W-1:0]              b_s1,
	output cmm_pkg::ctl_t                           res_q,
	output logic signed [cmm_pkg::ACC_W-1:0]        acc_re_q,
	output logic signed [cmm_pkg::ACC_W-1:0]        acc_im_q
);

	logic signed [cmm_pkg::COMP_W-1:0] ar, ai, br, bi;
	logic signed [cmm_pkg::PROD_W-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [cmm_pkg::CPX_W-1:0]  pre_s3, pim_s3;
	logic signed [cmm_pkg::ACC_W-1:0]  base_re, base_im;
	cmm_pkg::ctl_t                     ctl_s2, ctl_s3, res_d;

	assign ar = a_s1[cmm_pkg::ELEM_W-1:cmm_pkg::COMP_W];
	assign ai = a_s1[cmm_pkg::COMP_W-1:0];
	assign br = b_s1[cmm_pkg::ELEM_W-1:cmm_pkg::COMP_W];
	assign bi = b_s1[cmm_pkg::COMP_W-1:0];

	// four real products
	always_ff @(posedge clk) begin
		rr_s2 <= ar * br;
		ii_s2 <= ai * bi;
		ri_s2 <= ar * bi;
		ir_s2 <= ai * br;
	end

	// complex product
	always_ff @(posedge clk) begin
		pre_s3 <= cmm_pkg::CPX_W'(rr_s2) - cmm_pkg::CPX_W'(ii_s2);
		pim_s3 <= cmm_pkg::CPX_W'(ri_s2) + cmm_pkg::CPX_W'(ir_s2);
	end

	always_comb begin
		base_re = ctl_s3.first ? '0 : acc_re_q;
		base_im = ctl_s3.first ? '0 : acc_im_q;
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			acc_re_q <= base_re + cmm_pkg::ACC_W'(pre_s3);
			acc_im_q <= base_im + cmm_pkg::ACC_W'(pim_s3);
		end
	end

	// one strobe per element, on its last term
	always_comb begin
		res_d       = ctl_s3;
		res_d.valid = ctl_s3.valid & ctl_s3.last_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			res_q  <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			res_q  <= res_d;
		end
	end

endmodule

// ===== hw/rtl/complex_matrix_multiply_top.sv =====
`timescale 1ns / 1ps
// complex matrix multiply, C = A * B, DIM x DIM elements of Q1.15 components
// an item is taken at a rising edge with start high and busy low
// op load A / load B writes elem_re, elem_im at (row, col);
//   a load with row or col at DIM or above, and op 3, do nothing
// op compute raises busy and streams every element of C in row-major order
// each element of C appears for one cycle with valid high; last marks the
//   final element, and busy drops at the edge that ends that cycle
// the element store is two one-port-read rams, one for A, one for B; each
//   cycle reads one entry of each, so one complex multiply-accumulate per cycle
// a compute item issues DIM*DIM*DIM terms, k fastest, then j, then i; each term
//   passes the ram read, the product registers, the complex sum and the accumulator
// loads can be taken back to back
// results go out with no flow control: the receiver cannot stall the block
// reset clears the sequencer and the output strobe; the stores keep no reset
//   and an element must be loaded before a compute reads it
module complex_matrix_multiply_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [cmm_pkg::OP_W-1:0]                op,
	input  logic [cmm_pkg::IDX_W-1:0]               row,
	input  logic [cmm_pkg::IDX_W-1:0]               col,
	input  logic signed [cmm_pkg::COMP_W-1:0]       elem_re,
	input  logic signed [cmm_pkg::COMP_W-1:0]       elem_im,
	output logic                                    valid,
	output logic [cmm_pkg::IDX_W-1:0]               out_row,
	output logic [cmm_pkg::IDX_W-1:0]               out_col,
	output logic signed [cmm_pkg::ACC_W-1:0]        prod_re,
	output logic signed [cmm_pkg::ACC_W-1:0]        prod_im,
	output logic                                    last
);

	logic                              accept, in_range, we_a, we_b;
	logic [cmm_pkg::ADDR_W-1:0]        waddr, a_raddr, b_raddr;
	logic [cmm_pkg::ELEM_W-1:0]        wdata, a_s1, b_s1;
	logic                              busy_q, issue_q;
	logic [cmm_pkg::CNT_W-1:0]         i_q, j_q, k_q;
	logic                              k_end, j_end, i_end;
	cmm_pkg::ctl_t                     ctl_s1, res_q;
	logic signed [cmm_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;

	assign accept   = start & ~busy_q;
	assign in_range = (int'(row) < cmm_pkg::DIM) && (int'(col) < cmm_pkg::DIM);
	assign we_a     = accept && in_range && (op == cmm_pkg::OP_LOAD_A);
	assign we_b     = accept && in_range && (op == cmm_pkg::OP_LOAD_B);
	assign waddr    = cmm_pkg::ADDR_W'(int'(row) * cmm_pkg::DIM + int'(col));
	assign wdata    = {elem_re, elem_im};

	assign k_end = (k_q == cmm_pkg::CNT_W'(cmm_pkg::DIM - 1));
	assign j_end = (j_q == cmm_pkg::CNT_W'(cmm_pkg::DIM - 1));
	assign i_end = (i_q == cmm_pkg::CNT_W'(cmm_pkg::DIM - 1));

	assign a_raddr = cmm_pkg::ADDR_W'(int'(i_q) * cmm_pkg::DIM + int'(k_q));
	assign b_raddr = cmm_pkg::ADDR_W'(int'(k_q) * cmm_pkg::DIM + int'(j_q));

	cmm_ram #(.WIDTH(cmm_pkg::ELEM_W), .DEPTH(cmm_pkg::DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_raddr),
		.rdata (a_s1)
	);

	cmm_ram #(.WIDTH(cmm_pkg::ELEM_W), .DEPTH(cmm_pkg::DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (b_raddr),
		.rdata (b_s1)
	);

	// i, j, k sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1.valid  <= issue_q;
			ctl_s1.first  <= (k_q == '0);
			ctl_s1.last_k <= k_end;
			ctl_s1.row    <= cmm_pkg::IDX_W'(i_q);
			ctl_s1.col    <= cmm_pkg::IDX_W'(j_q);
			ctl_s1.last   <= i_end & j_end;
			if (accept && op == cmm_pkg::OP_COMPUTE) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
				k_q     <= '0;
			end else begin
				if (res_q.valid && res_q.last) begin
					busy_q <= 1'b0;
				end
				if (issue_q) begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								issue_q <= 1'b0;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end
		end
	end

	cmm_cmac u_cmac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.res_q    (res_q),
		.acc_re_q (acc_re_q),
		.acc_im_q (acc_im_q)
	);

	assign busy    = busy_q;
	assign valid   = res_q.valid;
	assign out_row = res_q.row;
	assign out_col = res_q.col;
	assign prod_re = acc_re_q;
	assign prod_im = acc_im_q;
	assign last    = res_q.valid & res_q.last;

	a_valid_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy_q) else $error("result strobe outside a compute");
	a_issue_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> busy_q) else $error("issue without busy");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy_q) else $error("busy held after last item");
	a_no_issue_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> !issue_q) else $error("issue still running at last result");
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start && op == cmm_pkg::OP_COMPUTE))
		else $error("busy rose without compute item");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cmm_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 24;
	localparam int DRAIN_CYCLES = DIM * DIM * DIM + DIM + 16;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [COMP_W-1:0] re;
		logic signed [COMP_W-1:0] im;
	} mat_item_t;

	typedef struct {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
		logic                    last;
	} prod_elem_t;

	logic                     clk     = 1'b0;
	logic                     arst_n  = 1'b0;
	logic                     start   = 1'b0;
	logic [OP_W-1:0]          op      = '0;
	logic [IDX_W-1:0]         row     = '0;
	logic [IDX_W-1:0]         col     = '0;
	logic signed [COMP_W-1:0] elem_re = '0;
	logic signed [COMP_W-1:0] elem_im = '0;
	logic                     busy;
	logic                     valid;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [ACC_W-1:0]  prod_re;
	logic signed [ACC_W-1:0]  prod_im;
	logic                     last;

	logic signed [COMP_W-1:0] a_re [DEPTH];
	logic signed [COMP_W-1:0] a_im [DEPTH];
	logic signed [COMP_W-1:0] b_re [DEPTH];
	logic signed [COMP_W-1:0] b_im [DEPTH];

	mat_item_t  item_q [$];
	prod_elem_t prod_q [$];
	mat_item_t  cur_item;
	prod_elem_t head_elem;
	int         idle_pct = 18;
	int         mismatches = 0;

	complex_matrix_multiply_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.op      (op),
		.row     (row),
		.col     (col),
		.elem_re (elem_re),
		.elem_im (elem_im),
		.valid   (valid),
		.out_row (out_row),
		.out_col (out_col),
		.prod_re (prod_re),
		.prod_im (prod_im),
		.last    (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic mat_item_t mk_item(logic [OP_W-1:0] o, int r, int c, int re, int im);
		mat_item_t it;
		it.op  = o;
		it.row = r[IDX_W-1:0];
		it.col = c[IDX_W-1:0];
		it.re  = re[COMP_W-1:0];
		it.im  = im[COMP_W-1:0];
		return it;
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// updates the matrix stores and queues the product elements of a compute
	task automatic apply_matrix_item(mat_item_t it);
		int         idx;
		longint     sr;
		longint     si;
		longint     ar;
		longint     ai;
		longint     br;
		longint     bi;
		prod_elem_t pe;
		if ((it.op == OP_LOAD_A || it.op == OP_LOAD_B) && it.row < DIM && it.col < DIM) begin
			idx = int'(it.row) * DIM + int'(it.col);
			if (it.op == OP_LOAD_A) begin
				a_re[idx] = it.re;
				a_im[idx] = it.im;
			end else begin
				b_re[idx] = it.re;
				b_im[idx] = it.im;
			end
		end else if (it.op == OP_COMPUTE) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					sr = 0;
					si = 0;
					for (int k = 0; k < DIM; k++) begin
						ar = a_re[i * DIM + k];
						ai = a_im[i * DIM + k];
						br = b_re[k * DIM + j];
						bi = b_im[k * DIM + j];
						sr += ar * br - ai * bi;
						si += ar * bi + ai * br;
					end
					pe.row  = i[IDX_W-1:0];
					pe.col  = j[IDX_W-1:0];
					pe.re   = sr[ACC_W-1:0];
					pe.im   = si[ACC_W-1:0];
					pe.last = (i == DIM - 1 && j == DIM - 1);
					prod_q.push_back(pe);
				end
			end
		end
	endtask

	function automatic void check_field(string name, logic [ACC_W-1:0] e, logic [ACC_W-1:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %h actual %h", $time, name, e, a);
			mismatches++;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				apply_matrix_item(cur_item);
			if (!start || !busy) begin
				if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cur_item = item_q.pop_front();
					op      <= cur_item.op;
					row     <= cur_item.row;
					col     <= cur_item.col;
					elem_re <= cur_item.re;
					elem_im <= cur_item.im;
					start   <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && valid === 1'b1) begin
			if (prod_q.size() == 0) begin
				$display("%0t: unexpected element row %0d col %0d", $time, out_row, out_col);
				mismatches++;
			end else begin
				head_elem = prod_q.pop_front();
				check_field("out_row", ACC_W'(head_elem.row), ACC_W'(out_row));
				check_field("out_col", ACC_W'(head_elem.col), ACC_W'(out_col));
				check_field("prod_re", head_elem.re, prod_re);
				check_field("prod_im", head_elem.im, prod_im);
				check_field("last", ACC_W'(head_elem.last), ACC_W'(last));
			end
		end
	end

	initial begin
		int counted;
		int r;
		int ri;
		int ci;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// full load of both matrices with extreme components
		for (int idx = 0; idx < DEPTH; idx++)
			item_q.push_back(mk_item(OP_LOAD_A, idx / DIM, idx % DIM,
				(idx % 2) ? 32767 : -32768, (idx % 3) ? -32768 : 32767));
		for (int idx = 0; idx < DEPTH; idx++)
			item_q.push_back(mk_item(OP_LOAD_B, idx / DIM, idx % DIM,
				-32768, (idx % 2) ? -32768 : 32767));
		item_q.push_back(mk_item(OP_COMPUTE, 7, 7, -1, -1));
		// out of range loads and unused opcode must change nothing
		item_q.push_back(mk_item(OP_LOAD_A, DIM, 0, 1234, -4321));
		item_q.push_back(mk_item(OP_LOAD_B, 0, 7, -1, 1));
		item_q.push_back(mk_item(OP_UNUSED, 0, 0, 0, 0));
		item_q.push_back(mk_item(OP_COMPUTE, 0, 0, 0, 0));

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 18 : (phase == 1) ? 75 : 0;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 10) begin
					if (r < 4 || DIM >= 8) begin
						item_q.push_back(mk_item(OP_UNUSED, $urandom_range(7),
							$urandom_range(7), rand_comp(), rand_comp()));
					end else begin
						ri = $urandom_range(7);
						ci = (ri < DIM) ? $urandom_range(7, DIM) : $urandom_range(7);
						item_q.push_back(mk_item((r % 2) ? OP_LOAD_B : OP_LOAD_A,
							ri, ci, rand_comp(), rand_comp()));
					end
				end else if (r < 22) begin
					item_q.push_back(mk_item(OP_COMPUTE, $urandom_range(7),
						$urandom_range(7), rand_comp(), rand_comp()));
					counted++;
				end else begin
					item_q.push_back(mk_item((r % 2) ? OP_LOAD_B : OP_LOAD_A,
						$urandom_range(DIM - 1), $urandom_range(DIM - 1),
						rand_comp(), rand_comp()));
					counted++;
				end
			end
			if (phase == 2)
				item_q.push_back(mk_item(OP_COMPUTE, 0, 0, 0, 0));
			while (item_q.size() != 0 || start)
				@(posedge clk);
		end

		while (prod_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && prod_q.size() == 0)
			$display("complex_matrix_multiply_top: match");
		else
			$display("complex_matrix_multiply_top: mismatch");
		$finish;
	end

	initial begin
		#1000000;
		$display("complex_matrix_multiply_top: mismatch");
		$finish;
	end

endmodule

// ===== complex_matrix_multiply_top.f =====
hw/rtl/cmm_pkg.sv
hw/rtl/cmm_ram.sv
hw/rtl/cmm_cmac.sv
hw/rtl/complex_matrix_multiply_top.sv
verif/tb.sv
